// ===== design/epsm_pkg.sv =====
package epsm_pkg;

    localparam int TIME_W = 16;
    localparam int REF_W  = 20;
    localparam int PPR_W  = 12;
    localparam int EPU_W  = 4;
    localparam int FREQ_W = 28;
    localparam int RPM_W  = 30;

    // shared divider: dividend and quotient width, divisor width
    localparam int DIV_W  = 30;
    localparam int DEN_W  = 28;
    localparam int STEP_W = $clog2(DIV_W + 1);

    localparam int MUL_A_W = 20;
    localparam int MUL_B_W = 16;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    localparam logic [MUL_B_W-1:0] RPM_SCALE = 16'd600;
    localparam logic [EPU_W-1:0]   CNT_MAX   = 4'd15;

    typedef logic [1:0] t_cfg_idx;

    localparam t_cfg_idx REG_REF_CLOCK_HZ     = 2'd0;
    localparam t_cfg_idx REG_PULSES_PER_REV   = 2'd1;
    localparam t_cfg_idx REG_EDGES_PER_UPDATE = 2'd2;

endpackage

// ===== design/epsm_div.sv =====
module epsm_div
    import epsm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIV_W-1:0] i_dividend,
    input  logic [DEN_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DIV_W-1:0] o_quotient
);

    logic [DIV_W-1:0]  r_quo;
    logic [DEN_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_den;
    logic [STEP_W-1:0] r_step;
    logic              r_busy;
    logic              r_done;

    logic [DEN_W:0] w_trial;
    logic [DEN_W:0] w_diff;
    logic           w_ge;

    // one restoring step per cycle
    assign w_trial = {r_rem, r_quo[DIV_W-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_ge    = (w_trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_den  <= i_divisor;
                r_step <= STEP_W'(DIV_W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem  <= w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
                r_quo  <= {r_quo[DIV_W-2:0], w_ge};
                r_step <= r_step - 1'b1;
                if (r_step == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== design/encoder_period_speed_meter.sv =====
// encoder period speed meter
// input channel: i_in_valid / o_in_stall carry one edge item (channel number and
// 16-bit capture time). an item is taken when valid is high and stall is low.
// output channel: o_out_valid / i_out_stall carry one speed result item. the
// result sits in an output register until taken; the block goes on to the next
// edge item while it waits there.
// config channel: i_cfg_valid / o_cfg_ready with a register index and data,
// always ready; write only while the block is idle.
// an edge that does not complete an update leaves the block idle. an edge with a zero
// interval (or zero pulses per revolution) skips the arithmetic and gives an error result.
// a normal result takes two passes through one shared multiplier, then two passes
// through one radix-2 restoring divider (frequency first, then rpm). o_in_stall
// stays high from the accepted edge until the result leaves the sequencer.
// if the receiver stalls, a finished result waits in the sequencer until the
// output register is free, and no new edge is taken meanwhile.
// synchronous reset clears the per-channel edge times and counters, restores the
// register defaults and drops any pending result.
module encoder_period_speed_meter
    import epsm_pkg::*;
#(
    parameter int CHANNELS = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_channel,
    input  logic [TIME_W-1:0] i_capture_time,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_out_channel,
    output logic [TIME_W-1:0] o_interval_ticks,
    output logic [FREQ_W-1:0] o_freq_q8,
    output logic [RPM_W-1:0]  o_rpm_tenths,
    output logic              o_divide_error,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  t_cfg_idx          i_cfg_index,
    input  logic [REF_W-1:0]  i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_NUM,
        S_DEN,
        S_FDIV,
        S_FWAIT,
        S_RDIV,
        S_RWAIT,
        S_FIN
    } t_state;

    t_state r_state;

    logic [REF_W-1:0]  r_ref;
    logic [PPR_W-1:0]  r_ppr;
    logic [EPU_W-1:0]  r_epu;

    logic [TIME_W-1:0] r_last [CHANNELS];
    logic [EPU_W-1:0]  r_cnt  [CHANNELS];

    logic              r_ch;
    logic [TIME_W-1:0] r_interval;
    logic [FREQ_W-1:0] r_freq;
    logic [RPM_W-1:0]  r_rpm;
    logic              r_err;
    logic [DIV_W-1:0]  r_num;
    logic [DEN_W-1:0]  r_den;

    logic              r_out_valid;
    logic              r_out_ch;
    logic [TIME_W-1:0] r_out_interval;
    logic [FREQ_W-1:0] r_out_freq;
    logic [RPM_W-1:0]  r_out_rpm;
    logic              r_out_err;

    logic              w_accept;
    logic              w_ch_ok;
    logic [TIME_W-1:0] w_last_sel;
    logic [EPU_W-1:0]  w_cnt_sel;
    logic [EPU_W-1:0]  w_cnt_inc;
    logic [EPU_W-1:0]  w_need;
    logic              w_emit;
    logic [TIME_W-1:0] w_interval;
    logic              w_err;
    logic              w_out_free;

    logic [MUL_A_W-1:0] w_mul_a;
    logic [MUL_B_W-1:0] w_mul_b;
    logic [PROD_W-1:0]  w_prod;

    logic              w_div_start;
    logic [DIV_W-1:0]  w_div_dividend;
    logic [DEN_W-1:0]  w_div_divisor;
    logic              w_div_done;
    logic [DIV_W-1:0]  w_div_quotient;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_ch_ok    = (int'(i_channel) < CHANNELS);
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        w_last_sel = '0;
        w_cnt_sel  = '0;
        for (int i = 0; i < CHANNELS; i++) begin
            if (int'(i_channel) == i) begin
                w_last_sel = r_last[i];
                w_cnt_sel  = r_cnt[i];
            end
        end
    end

    assign w_cnt_inc  = (w_cnt_sel == CNT_MAX) ? CNT_MAX : w_cnt_sel + 1'b1;
    assign w_need     = (r_epu == '0) ? EPU_W'(1) : r_epu;
    assign w_emit     = (w_cnt_inc >= w_need);
    assign w_interval = i_capture_time - w_last_sel;
    assign w_err      = (w_interval == '0) || (r_ppr == '0);

    // shared multiplier
    always_comb begin
        if (r_state == S_NUM) begin
            w_mul_a = r_ref;
            w_mul_b = RPM_SCALE;
        end else begin
            w_mul_a = MUL_A_W'(r_ppr);
            w_mul_b = r_interval;
        end
    end

    assign w_prod = PROD_W'(w_mul_a) * PROD_W'(w_mul_b);

    assign w_div_start    = (r_state == S_FDIV) || (r_state == S_RDIV);
    assign w_div_dividend = (r_state == S_FDIV) ? DIV_W'({r_ref, 8'd0}) : r_num;
    assign w_div_divisor  = (r_state == S_FDIV) ? DEN_W'(r_interval) : r_den;

    epsm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (w_div_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_div_quotient)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref <= REF_W'(32768);
            r_ppr <= PPR_W'(48);
            r_epu <= EPU_W'(2);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_REF_CLOCK_HZ:     r_ref <= i_cfg_data;
                REG_PULSES_PER_REV:   r_ppr <= i_cfg_data[PPR_W-1:0];
                REG_EDGES_PER_UPDATE: r_epu <= i_cfg_data[EPU_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_last[i] <= '0;
                r_cnt[i]  <= '0;
            end
        end else begin
            if (r_out_valid && !i_out_stall && (r_state != S_FIN)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept && w_ch_ok) begin
                        for (int i = 0; i < CHANNELS; i++) begin
                            if (int'(i_channel) == i) begin
                                r_last[i] <= i_capture_time;
                                r_cnt[i]  <= w_emit ? '0 : w_cnt_inc;
                            end
                        end
                        r_ch       <= i_channel;
                        r_interval <= w_interval;
                        r_err      <= w_err;
                        r_freq     <= '0;
                        r_rpm      <= '0;
                        if (w_emit) begin
                            r_state <= w_err ? S_FIN : S_NUM;
                        end
                    end
                end
                S_NUM: begin
                    r_num   <= w_prod[DIV_W-1:0];
                    r_state <= S_DEN;
                end
                S_DEN: begin
                    r_den   <= w_prod[DEN_W-1:0];
                    r_state <= S_FDIV;
                end
                S_FDIV: begin
                    r_state <= S_FWAIT;
                end
                S_FWAIT: begin
                    if (w_div_done) begin
                        r_freq  <= w_div_quotient[FREQ_W-1:0];
                        r_state <= S_RDIV;
                    end
                end
                S_RDIV: begin
                    r_state <= S_RWAIT;
                end
                S_RWAIT: begin
                    if (w_div_done) begin
                        r_rpm   <= w_div_quotient[RPM_W-1:0];
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_out_valid    <= 1'b1;
                        r_out_ch       <= r_ch;
                        r_out_interval <= r_interval;
                        r_out_freq     <= r_freq;
                        r_out_rpm      <= r_rpm;
                        r_out_err      <= r_err;
                        r_state        <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall       = (r_state != S_IDLE);
    assign o_cfg_ready      = 1'b1;
    assign o_out_valid      = r_out_valid;
    assign o_out_channel    = r_out_ch;
    assign o_interval_ticks = r_out_interval;
    assign o_freq_q8        = r_out_freq;
    assign o_rpm_tenths     = r_out_rpm;
    assign o_divide_error   = r_out_err;

endmodule

// ===== design/epsm_chk.sv =====
module epsm_chk
    import epsm_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic              o_out_channel,
    input logic [TIME_W-1:0] o_interval_ticks,
    input logic [FREQ_W-1:0] o_freq_q8,
    input logic [RPM_W-1:0]  o_rpm_tenths,
    input logic              o_divide_error
);

    // a stalled result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_channel)
            && $stable(o_interval_ticks) && $stable(o_freq_q8)
            && $stable(o_rpm_tenths) && $stable(o_divide_error))
        else $error("result changed while stalled");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_divide_error |-> o_freq_q8 == '0 && o_rpm_tenths == '0)
        else $error("error result with nonzero speed");

    a_zero_interval_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_interval_ticks == '0 |-> o_divide_error)
        else $error("zero interval without error flag");

endmodule

bind encoder_period_speed_meter epsm_chk u_epsm_chk (.*);

// ===== tb/speed_result_checker.sv =====
`timescale 1ns / 1ps

module speed_result_checker
    import epsm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  logic              i_channel,
    input  logic [TIME_W-1:0] i_capture_time,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic              i_out_channel,
    input  logic [TIME_W-1:0] i_interval_ticks,
    input  logic [FREQ_W-1:0] i_freq_q8,
    input  logic [RPM_W-1:0]  i_rpm_tenths,
    input  logic              i_divide_error,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_ready,
    input  t_cfg_idx          i_cfg_index,
    input  logic [REF_W-1:0]  i_cfg_data,
    output int                o_mismatches,
    output int                o_pending,
    output int                o_results
);

    localparam logic [EPU_W-1:0] EDGE_CNT_SAT   = 4'd15;
    localparam longint unsigned  TENTHS_PER_HZ  = 600;

    typedef struct packed {
        logic              ch;
        logic [TIME_W-1:0] ticks;
        logic [FREQ_W-1:0] freq;
        logic [RPM_W-1:0]  rpm;
        logic              err;
    } t_speed;

    t_speed            expected_speeds[$];
    logic [TIME_W-1:0] last_time[2];
    logic [EPU_W-1:0]  edge_cnt[2];
    logic [REF_W-1:0]  ref_hz;
    logic [PPR_W-1:0]  ppr;
    logic [EPU_W-1:0]  epu;
    int                mismatch_count = 0;
    int                results_checked = 0;
    int                pending_count = 0;

    assign o_mismatches = mismatch_count;
    assign o_pending    = pending_count;
    assign o_results    = results_checked;

    task automatic report_mismatch(input string msg);
        $display("%0t mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input longint unsigned got,
                               input longint unsigned want);
        if (got != want) begin
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
        end
    endtask

    function automatic bit predict_speed(input logic ch, input logic [TIME_W-1:0] t,
                                         output t_speed r);
        logic [TIME_W-1:0] ticks;
        logic [EPU_W-1:0]  need;
        logic [63:0]       freq;
        logic [63:0]       rpm;
        ticks = t - last_time[ch];
        last_time[ch] = t;
        if (edge_cnt[ch] < EDGE_CNT_SAT) begin
            edge_cnt[ch] = edge_cnt[ch] + 1'b1;
        end
        need = (epu == '0) ? EPU_W'(1) : epu;
        r.ch    = ch;
        r.ticks = ticks;
        r.freq  = '0;
        r.rpm   = '0;
        r.err   = 1'b1;
        if (edge_cnt[ch] < need) begin
            return 1'b0;
        end
        edge_cnt[ch] = '0;
        if (ticks != '0 && ppr != '0) begin
            freq   = (64'(ref_hz) << 8) / 64'(ticks);
            rpm    = (64'(ref_hz) * TENTHS_PER_HZ) / (64'(ppr) * 64'(ticks));
            r.freq = freq[FREQ_W-1:0];
            r.rpm  = rpm[RPM_W-1:0];
            r.err  = 1'b0;
        end
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin
        t_speed want;
        t_speed fresh;
        if (!i_rst_n) begin
            expected_speeds.delete();
            last_time[0] = '0;
            last_time[1] = '0;
            edge_cnt[0]  = '0;
            edge_cnt[1]  = '0;
            ref_hz       = 20'd32768;
            ppr          = 12'd48;
            epu          = 4'd2;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                results_checked++;
                if (expected_speeds.size() == 0) begin
                    report_mismatch($sformatf("unexpected result on channel %0d",
                                              i_out_channel));
                end else begin
                    want = expected_speeds.pop_front();
                    check_field("out_channel", i_out_channel, want.ch);
                    check_field("interval_ticks", i_interval_ticks, want.ticks);
                    check_field("freq_q8", i_freq_q8, want.freq);
                    check_field("rpm_tenths", i_rpm_tenths, want.rpm);
                    check_field("divide_error", i_divide_error, want.err);
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_REF_CLOCK_HZ:     ref_hz = i_cfg_data[REF_W-1:0];
                    REG_PULSES_PER_REV:   ppr    = i_cfg_data[PPR_W-1:0];
                    REG_EDGES_PER_UPDATE: epu    = i_cfg_data[EPU_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                if (predict_speed(i_channel, i_capture_time, fresh)) begin
                    expected_speeds.push_back(fresh);
                end
            end
        end
        pending_count = expected_speeds.size();
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import epsm_pkg::*;

    localparam t_cfg_idx REG_UNUSED   = 2'd3;
    localparam int       SETTLE_CYCLES = 100;
    localparam int       HOLD_CYCLES   = 400;
    localparam int       PHASES        = 8;
    localparam int       PHASE_ITEMS   = 56;
    localparam int       QUIET_PHASE   = 1;
    localparam int       HOLD_PHASE    = 2;
    localparam int       PAUSE_PHASE   = 4;
    localparam int       EPU_MAX_PHASE = 5;
    localparam int       ZERO_PHASE    = 6;
    localparam longint   WATCHDOG_NS   = 5_000_000;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic              in_channel;
    logic [TIME_W-1:0] in_time;
    logic              out_valid;
    logic              out_stall;
    logic              out_channel;
    logic [TIME_W-1:0] out_ticks;
    logic [FREQ_W-1:0] out_freq;
    logic [RPM_W-1:0]  out_rpm;
    logic              out_err;
    logic              cfg_valid;
    logic              cfg_ready;
    t_cfg_idx          cfg_index;
    logic [REF_W-1:0]  cfg_data;

    int                mismatches;
    int                pending;
    int                results_checked;
    int                items_sent = 0;
    int                settings_applied = 0;
    logic [TIME_W-1:0] last_sent[2] = '{16'd0, 16'd0};
    bit                quiet = 1'b0;
    bit                hold_req = 1'b0;
    bit                hold_done = 1'b0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    encoder_period_speed_meter uut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_channel        (in_channel),
        .i_capture_time   (in_time),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_out_channel    (out_channel),
        .o_interval_ticks (out_ticks),
        .o_freq_q8        (out_freq),
        .o_rpm_tenths     (out_rpm),
        .o_divide_error   (out_err),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data)
    );

    speed_result_checker u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_channel        (in_channel),
        .i_capture_time   (in_time),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_out_channel    (out_channel),
        .i_interval_ticks (out_ticks),
        .i_freq_q8        (out_freq),
        .i_rpm_tenths     (out_rpm),
        .i_divide_error   (out_err),
        .i_cfg_valid      (cfg_valid),
        .i_cfg_ready      (cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .o_mismatches     (mismatches),
        .o_pending        (pending),
        .o_results        (results_checked)
    );

    // receiver side: random stalls, one long hold-off
    initial begin
        int n;
        out_stall <= 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req && !hold_done) begin
                out_stall <= 1'b1;
                for (n = 0; n < HOLD_CYCLES; n++) begin
                    @(negedge clk);
                end
                hold_done = 1'b1;
            end
            out_stall <= !quiet && ($urandom_range(99) < 13);
        end
    end

    initial begin
        #(WATCHDOG_NS);
        $display("Mismatches found");
        $finish;
    end

    task automatic send_edge(input logic ch, input logic [TIME_W-1:0] t);
        while (!quiet && $urandom_range(99) < 13) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        in_channel <= ch;
        in_time    <= t;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        last_sent[ch] = t;
        items_sent++;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [REF_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
    endtask

    task automatic apply_settings(input logic [REF_W-1:0] ref_v,
                                  input logic [PPR_W-1:0] ppr_v,
                                  input logic [EPU_W-1:0] epu_v);
        settle();
        write_reg(REG_UNUSED, REF_W'($urandom));
        write_reg(REG_REF_CLOCK_HZ, ref_v);
        write_reg(REG_PULSES_PER_REV, {8'($urandom), ppr_v});
        write_reg(REG_EDGES_PER_UPDATE, {16'($urandom), epu_v});
        cfg_valid <= 1'b0;
        settings_applied++;
    endtask

    task automatic pick_settings(input int ph);
        logic [REF_W-1:0] ref_v;
        logic [PPR_W-1:0] ppr_v;
        logic [EPU_W-1:0] epu_v;
        case ($urandom_range(3))
            0:       ref_v = 20'd1;
            1:       ref_v = '1;
            default: ref_v = REF_W'($urandom_range(1, 20'hFFFFF));
        endcase
        case ($urandom_range(3))
            0:       ppr_v = 12'd1;
            1:       ppr_v = '1;
            default: ppr_v = PPR_W'($urandom_range(1, 12'hFFF));
        endcase
        epu_v = EPU_W'($urandom_range(1, 4));
        if (ph == EPU_MAX_PHASE) begin
            epu_v = 4'd15;
        end
        if (ph == ZERO_PHASE) begin
            ref_v = '0;
            epu_v = '0;
        end
        apply_settings(ref_v, ppr_v, epu_v);
    endtask

    task automatic random_phase(input int ph);
        int                i;
        int                pick;
        logic              ch;
        logic [TIME_W-1:0] t;
        for (i = 0; i < PHASE_ITEMS; i++) begin
            if (ph == PAUSE_PHASE && i == PHASE_ITEMS / 2) begin
                in_valid <= 1'b0;
                do @(negedge clk); while (pending != 0);
            end
            ch   = 1'($urandom_range(1));
            pick = $urandom_range(99);
            if (pick < 8) begin
                t = TIME_W'($urandom_range(16'hFFFF));
            end else if (pick < 14) begin
                t = last_sent[ch];
            end else if (pick < 50) begin
                t = last_sent[ch] + TIME_W'($urandom_range(1, 60));
            end else if (pick < 85) begin
                t = last_sent[ch] + TIME_W'($urandom_range(61, 8000));
            end else begin
                t = last_sent[ch] + TIME_W'($urandom_range(8001, 16'hFFFF));
            end
            send_edge(ch, t);
        end
    endtask

    initial begin
        int ph;
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        in_channel <= 1'b0;
        in_time    <= '0;
        cfg_valid  <= 1'b0;
        cfg_index  <= REG_REF_CLOCK_HZ;
        cfg_data   <= '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset defaults: first edge from time zero, zero interval, wrap both ways
        send_edge(1'b0, 16'h0000);
        send_edge(1'b0, 16'h0000);
        send_edge(1'b1, 16'hFFFF);
        send_edge(1'b1, 16'hFFFE);
        send_edge(1'b0, 16'hFFFF);
        send_edge(1'b0, 16'h0000);

        // full-scale clock, one pulse per rev, every edge updates
        apply_settings('1, 12'd1, 4'd1);
        send_edge(1'b0, 16'h0001);
        send_edge(1'b1, 16'h0000);
        send_edge(1'b0, 16'h0000);
        send_edge(1'b1, 16'h0000);
        send_edge(1'b0, 16'h8000);
        send_edge(1'b1, 16'h7FFF);

        // slowest clock, most pulses, update count of zero
        apply_settings(20'd1, '1, 4'd0);
        send_edge(1'b0, 16'h8001);
        send_edge(1'b0, 16'h8000);
        send_edge(1'b1, 16'hFFFF);

        // zero pulses per rev
        apply_settings(20'd32768, 12'd0, 4'd1);
        send_edge(1'b0, 16'h1234);
        send_edge(1'b1, 16'hFFFF);

        for (ph = 0; ph < PHASES; ph++) begin
            pick_settings(ph);
            quiet    = (ph == QUIET_PHASE);
            hold_req = hold_req || (ph == HOLD_PHASE);
            random_phase(ph);
        end
        quiet = 1'b0;

        settle();
        $display("sent %0d edge items, checked %0d speed results", items_sent,
                 results_checked);
        $display("%0d register settings used, zero and full-scale values among them",
                 settings_applied);
        if (mismatches == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== encoder_period_speed_meter.f =====
design/epsm_pkg.sv
design/epsm_div.sv
design/encoder_period_speed_meter.sv
design/epsm_chk.sv
tb/speed_result_checker.sv
tb/tb_top.sv
